// File: rtl/cdc_pkg.sv
package cdc_pkg;

    // calendar limits
    localparam logic [13:0] MAX_YEAR  = 14'd9999;
    localparam logic [13:0] MIN_YEAR  = 14'd1;
    localparam logic [13:0] RST_YEAR  = 14'd1900;

    // month numbers
    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    // day counts
    localparam logic [4:0] DAY_FIRST = 5'd1;
    localparam logic [4:0] LEN_28    = 5'd28;
    localparam logic [4:0] LEN_29    = 5'd29;
    localparam logic [4:0] LEN_30    = 5'd30;
    localparam logic [4:0] LEN_31    = 5'd31;
    localparam logic [4:0] LEN_NONE  = 5'd0;

    // action codes
    localparam logic [1:0] ACT_NEXT   = 2'd0;
    localparam logic [1:0] ACT_PREV   = 2'd1;
    localparam logic [1:0] ACT_LOAD   = 2'd2;
    localparam logic [1:0] ACT_BACK_N = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_LIMIT   = 2'd2;

    // divisibility by 25: multiply by the inverse of 25 modulo 2^14 and compare
    localparam logic [13:0] INV25       = 14'd7209;
    localparam logic [13:0] DIV25_LIMIT = 14'd655;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } date_t;

    localparam date_t DATE_RESET = '{day: DAY_FIRST, month: MON_JAN, year: RST_YEAR};

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } cdc_state_t;

    // leap year: divisible by 4 and not by 100, or divisible by 400
    function automatic logic cdc_is_leap(input logic [13:0] y);
        logic [13:0] prod;
        logic        div25;
        prod  = 14'(y * INV25);
        div25 = (prod <= DIV25_LIMIT);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    // days in a month, zero for a month outside 1 to 12
    function automatic logic [4:0] cdc_month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
            MON_FEB:                            len = leap ? LEN_29 : LEN_28;
            [MON_JAN:MON_DEC]:                  len = LEN_31;
            default:                            len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/cdc_step_unit.sv
module cdc_step_unit
    import cdc_pkg::*;
(
    input  date_t cur,
    input  logic  dir_back,
    output date_t nxt,
    output logic  ok
);

    logic       leap;
    logic [4:0] len_cur;
    logic [3:0] month_dec;
    logic [4:0] len_prev;

    // month lengths for the current and the previous month of this year
    assign leap      = cdc_is_leap(cur.year);
    assign len_cur   = cdc_month_len(cur.month, leap);
    assign month_dec = 4'(cur.month - 4'd1);
    assign len_prev  = cdc_month_len(month_dec, leap);

    // one day forward or back, held at the calendar limits
    always_comb begin
        nxt = cur;
        ok  = 1'b1;
        if (!dir_back) begin
            if (cur.day < len_cur) begin
                nxt.day = 5'(cur.day + 5'd1);
            end else if (cur.month < MON_DEC) begin
                nxt.month = 4'(cur.month + 4'd1);
                nxt.day   = DAY_FIRST;
            end else if (cur.year < MAX_YEAR) begin
                nxt.year  = 14'(cur.year + 14'd1);
                nxt.month = MON_JAN;
                nxt.day   = DAY_FIRST;
            end else begin
                ok = 1'b0;
            end
        end else begin
            if (cur.day > DAY_FIRST) begin
                nxt.day = 5'(cur.day - 5'd1);
            end else if (cur.month > MON_JAN) begin
                nxt.month = month_dec;
                nxt.day   = len_prev;
            end else if (cur.year > MIN_YEAR) begin
                nxt.year  = 14'(cur.year - 14'd1);
                nxt.month = MON_DEC;
                nxt.day   = LEN_31;
            end else begin
                ok = 1'b0;
            end
        end
    end

endmodule

// File: rtl/cdc_load_check.sv
module cdc_load_check
    import cdc_pkg::*;
(
    input  date_t req,
    output logic  valid
);

    logic       leap;
    logic [4:0] len;

    assign leap = cdc_is_leap(req.year);
    assign len  = cdc_month_len(req.month, leap);

    // month and year in range, day inside the month
    assign valid = (req.month >= MON_JAN) && (req.month <= MON_DEC)
                && (req.year >= MIN_YEAR) && (req.year <= MAX_YEAR)
                && (req.day >= DAY_FIRST) && (req.day <= len);

endmodule

// File: rtl/calendar_date_counter.sv
// channel   direction  ports
// s_        in         s_valid s_ready s_action s_day s_month s_year s_count
// m_        out        m_valid m_ready m_cur_day m_cur_month m_cur_year m_status
//
// one transaction at a time: accept, execute, then hold the result until taken
// next day, previous day and load: a single execute state, then the output state
// go back count days: one pass of the shared day step unit per cycle in the
// execute state until the count runs out or a calendar limit is reached
// reset restores 1/1/1900; s_ready stays low until the result is taken
module calendar_date_counter
    import cdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [4:0]  s_day,
    input  logic [3:0]  s_month,
    input  logic [13:0] s_year,
    input  logic [15:0] s_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_cur_day,
    output logic [3:0]  m_cur_month,
    output logic [13:0] m_cur_year,
    output logic [1:0]  m_status
);

    cdc_state_t  state_reg, state_next;
    date_t       date_reg, date_next;
    date_t       load_reg;
    logic [1:0]  act_reg;
    logic [15:0] count_reg, count_next;
    logic [1:0]  status_reg, status_next;

    date_t       step_date;
    logic        step_ok;
    logic        load_ok;
    logic        exec_done;
    logic        s_accept;

    assign s_accept = s_valid && s_ready;

    // shared one-day step unit
    cdc_step_unit u_step (
        .cur      (date_reg),
        .dir_back (act_reg != ACT_NEXT),
        .nxt      (step_date),
        .ok       (step_ok)
    );

    cdc_load_check u_check (
        .req   (load_reg),
        .valid (load_ok)
    );

    // datapath for the execute state
    always_comb begin
        date_next   = date_reg;
        count_next  = count_reg;
        status_next = status_reg;
        exec_done   = 1'b1;
        if (state_reg == S_EXEC) begin
            unique case (act_reg) inside
                ACT_NEXT, ACT_PREV: begin
                    if (step_ok) begin
                        date_next = step_date;
                    end else begin
                        status_next = STAT_LIMIT;
                    end
                end
                ACT_LOAD: begin
                    if (load_ok) begin
                        date_next = load_reg;
                    end else begin
                        status_next = STAT_INVALID;
                    end
                end
                ACT_BACK_N: begin
                    if (count_reg != 16'd0) begin
                        if (step_ok) begin
                            date_next  = step_date;
                            count_next = 16'(count_reg - 16'd1);
                            exec_done  = (count_reg == 16'd1);
                        end else begin
                            status_next = STAT_LIMIT;
                        end
                    end
                end
                default: begin
                    exec_done = 1'b1;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_accept) state_next = S_EXEC;
            S_EXEC: if (exec_done) state_next = S_OUT;
            S_OUT:  if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:  s_ready = 1'b1;
            S_EXEC:  s_ready = 1'b0;
            S_OUT:   m_valid = 1'b1;
            default: s_ready = 1'b0;
        endcase
    end

    assign m_cur_day   = date_reg.day;
    assign m_cur_month = date_reg.month;
    assign m_cur_year  = date_reg.year;
    assign m_status    = status_reg;

    // control and date state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            date_reg  <= DATE_RESET;
        end else begin
            state_reg <= state_next;
            date_reg  <= date_next;
        end
    end

    // transaction capture and working registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg    <= s_action;
            load_reg   <= '{day: s_day, month: s_month, year: s_year};
            count_reg  <= s_count;
            status_reg <= STAT_OK;
        end else begin
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

`ifndef SYNTHESIS
    // never ready for input while a result is offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // held month and year always inside the calendar, day never below the first
    assert property (@(posedge aclk) disable iff (!aresetn)
        (date_reg.month >= MON_JAN) && (date_reg.month <= MON_DEC) &&
        (date_reg.day >= DAY_FIRST) && (date_reg.year >= MIN_YEAR) &&
        (date_reg.year <= MAX_YEAR))
        else $error("held date out of range");

    // only a load can report an invalid date
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (act_reg != ACT_LOAD)) |-> (m_status != STAT_INVALID))
        else $error("invalid status on a step action");

    // a rejected load leaves the date unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_EXEC) && (act_reg == ACT_LOAD) && !load_ok)
        |=> $stable(date_reg))
        else $error("rejected load changed the date");
`endif

endmodule

// File: verif/tb.sv
module tb
    import cdc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // one transaction on each channel
    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [15:0] count;
    } date_request_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [1:0]  status;
    } date_reply_t;

    // tracks the held date and checks each reply against it
    class calendar_tracker;
        logic [4:0]  day_q;
        logic [3:0]  month_q;
        logic [13:0] year_q;
        date_reply_t pending[$];
        int unsigned errors;
        int unsigned requests;
        int unsigned replies;
        int unsigned per_action[4];
        int unsigned per_status[4];

        function new();
            day_q    = DAY_FIRST;
            month_q  = MON_JAN;
            year_q   = RST_YEAR;
            errors   = 0;
            requests = 0;
            replies  = 0;
            foreach (per_action[i]) per_action[i] = 0;
            foreach (per_status[i]) per_status[i] = 0;
        endfunction

        function bit leap_year(logic [13:0] y);
            int unsigned v;
            v = y;
            return ((v % 4 == 0) && (v % 100 != 0)) || (v % 400 == 0);
        endfunction

        function logic [4:0] days_in(logic [3:0] m, logic [13:0] y);
            logic [4:0] len;
            case (m) inside
                MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
                MON_FEB: len = leap_year(y) ? LEN_29 : LEN_28;
                default: len = (m >= MON_JAN && m <= MON_DEC) ? LEN_31 : LEN_NONE;
            endcase
            return len;
        endfunction

        // one day forward, zero when held at the top of the calendar
        function bit advance();
            if (day_q < days_in(month_q, year_q)) begin
                day_q = day_q + 1'b1;
            end else if (month_q < MON_DEC) begin
                month_q = month_q + 1'b1;
                day_q   = DAY_FIRST;
            end else if (year_q < MAX_YEAR) begin
                year_q  = year_q + 1'b1;
                month_q = MON_JAN;
                day_q   = DAY_FIRST;
            end else begin
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // one day back, zero when held at 1/1/1
        function bit retreat();
            if (day_q > DAY_FIRST) begin
                day_q = day_q - 1'b1;
            end else if (month_q > MON_JAN) begin
                month_q = month_q - 1'b1;
                day_q   = days_in(month_q, year_q);
            end else if (year_q > MIN_YEAR) begin
                year_q  = year_q - 1'b1;
                month_q = MON_DEC;
                day_q   = LEN_31;
            end else begin
                return 1'b0;
            end
            return 1'b1;
        endfunction

        // apply an accepted request and queue the date it should produce
        function void note_request(date_request_t req);
            date_reply_t exp;
            logic [1:0]  st;
            int unsigned n;
            st = STAT_OK;
            case (req.action)
                ACT_NEXT: begin
                    if (!advance()) st = STAT_LIMIT;
                end
                ACT_PREV: begin
                    if (!retreat()) st = STAT_LIMIT;
                end
                ACT_LOAD: begin
                    if (req.month >= MON_JAN && req.month <= MON_DEC &&
                        req.year >= MIN_YEAR && req.year <= MAX_YEAR &&
                        req.day >= DAY_FIRST && req.day <= days_in(req.month, req.year)) begin
                        day_q   = req.day;
                        month_q = req.month;
                        year_q  = req.year;
                    end else begin
                        st = STAT_INVALID;
                    end
                end
                default: begin
                    n = 0;
                    while (n < req.count && st == STAT_OK) begin
                        if (!retreat()) st = STAT_LIMIT;
                        n++;
                    end
                end
            endcase
            exp = '{day: day_q, month: month_q, year: year_q, status: st};
            pending.push_back(exp);
            requests++;
            per_action[req.action]++;
            per_status[st]++;
        endfunction

        // compare a reply with the oldest expected date
        function void check_reply(date_reply_t got);
            date_reply_t exp;
            replies++;
            if (pending.size() == 0) begin
                $error("reply with nothing expected: %0d/%0d/%0d status %0d",
                       got.day, got.month, got.year, got.status);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.day !== exp.day) begin
                $error("cur_day mismatch: expected %0d, got %0d", exp.day, got.day);
                errors++;
            end
            if (got.month !== exp.month) begin
                $error("cur_month mismatch: expected %0d, got %0d", exp.month, got.month);
                errors++;
            end
            if (got.year !== exp.year) begin
                $error("cur_year mismatch: expected %0d, got %0d", exp.year, got.year);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status mismatch: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [4:0]  s_day;
    logic [3:0]  s_month;
    logic [13:0] s_year;
    logic [15:0] s_count;
    logic        m_valid;
    logic        m_ready;
    logic [4:0]  m_cur_day;
    logic [3:0]  m_cur_month;
    logic [13:0] m_cur_year;
    logic [1:0]  m_status;

    calendar_tracker trk = new();
    bit steady_send = 1'b0;
    bit held_off    = 1'b0;

    calendar_date_counter uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_day       (s_day),
        .s_month     (s_month),
        .s_year      (s_year),
        .s_count     (s_count),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cur_day   (m_cur_day),
        .m_cur_month (m_cur_month),
        .m_cur_year  (m_cur_year),
        .m_status    (m_status)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // offer one transaction and hold it until taken, then maybe idle
    task automatic send_item(input logic [1:0] act, input logic [4:0] d, input logic [3:0] m,
                             input logic [13:0] y, input logic [15:0] c);
        date_request_t req;
        req = '{action: act, day: d, month: m, year: y, count: c};
        s_valid  <= 1'b1;
        s_action <= act;
        s_day    <= d;
        s_month  <= m;
        s_year   <= y;
        s_count  <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        trk.note_request(req);
        if (!steady_send && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // wait for the block to drain with the input idle
    task automatic drain();
        s_valid <= 1'b0;
        while (trk.pending.size() != 0) @(posedge aclk);
    endtask

    // stimulus
    initial begin
        int unsigned idx;
        int unsigned pick;
        int unsigned k;
        logic [1:0]  act;
        logic [4:0]  d;
        logic [3:0]  m;
        logic [13:0] y;
        logic [15:0] c;
        logic [4:0]  len;

        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_action <= ACT_NEXT;
        s_day    <= '0;
        s_month  <= '0;
        s_year   <= '0;
        s_count  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // steps across month and year edges from the reset date
        send_item(ACT_NEXT, 5'd0, 4'd0, 14'd0, 16'd0);
        send_item(ACT_PREV, 5'd0, 4'd0, 14'd0, 16'd0);
        send_item(ACT_PREV, 5'd0, 4'd0, 14'd0, 16'd0);
        // century years are not leap unless divisible by 400
        send_item(ACT_LOAD, 5'd28, MON_FEB, 14'd1900, 16'd0);
        send_item(ACT_NEXT, 5'd0, 4'd0, 14'd0, 16'd0);
        send_item(ACT_LOAD, 5'd29, MON_FEB, 14'd1900, 16'd0);
        send_item(ACT_LOAD, 5'd29, MON_FEB, 14'd2000, 16'd0);
        send_item(ACT_NEXT, 5'd0, 4'd0, 14'd0, 16'd0);
        send_item(ACT_PREV, 5'd0, 4'd0, 14'd0, 16'd0);
        send_item(ACT_LOAD, 5'd29, MON_FEB, 14'd2023, 16'd0);
        // rejected loads: short month, all zeros, all ones, year past the top
        send_item(ACT_LOAD, 5'd31, MON_APR, 14'd2021, 16'd0);
        send_item(ACT_LOAD, 5'd0, 4'd0, 14'd0, 16'd0);
        send_item(ACT_LOAD, 5'd31, 4'd15, 14'd16383, 16'hffff);
        send_item(ACT_LOAD, DAY_FIRST, MON_JAN, MAX_YEAR + 14'd1, 16'd0);
        // top of the calendar, then the longest step back
        send_item(ACT_LOAD, 5'd31, MON_DEC, MAX_YEAR, 16'd0);
        send_item(ACT_NEXT, 5'd0, 4'd0, 14'd0, 16'd0);
        send_item(ACT_BACK_N, 5'd0, 4'd0, 14'd0, 16'hffff);
        // bottom of the calendar
        send_item(ACT_LOAD, DAY_FIRST, MON_JAN, MIN_YEAR, 16'd0);
        send_item(ACT_PREV, 5'd0, 4'd0, 14'd0, 16'd0);
        send_item(ACT_BACK_N, 5'd0, 4'd0, 14'd0, 16'd0);
        send_item(ACT_BACK_N, 5'd0, 4'd0, 14'd0, 16'd1);
        // reaching 1/1/1 on the last step is fine, one more step is not
        send_item(ACT_LOAD, 5'd3, MON_JAN, MIN_YEAR, 16'd0);
        send_item(ACT_BACK_N, 5'd0, 4'd0, 14'd0, 16'd2);
        send_item(ACT_NEXT, 5'd0, 4'd0, 14'd0, 16'd0);
        send_item(ACT_BACK_N, 5'd0, 4'd0, 14'd0, 16'd5);
        send_item(ACT_LOAD, DAY_FIRST, 4'd3, 14'd50, 16'd0);
        send_item(ACT_BACK_N, 5'd0, 4'd0, 14'd0, 16'hffff);

        // let every reply come back before the random part
        drain();

        // random part: mostly well-formed loads and steps, some bad loads
        for (idx = 0; idx < 430; idx++) begin
            steady_send = (idx >= 200 && idx < 290);
            d    = 5'($urandom_range(31));
            m    = 4'($urandom_range(15));
            y    = 14'($urandom_range(16383));
            c    = 16'($urandom_range(65535));
            pick = $urandom_range(99);
            if (pick < 30) begin
                act = ACT_LOAD;
                k   = $urandom_range(9);
                if ($urandom_range(4) != 0) begin
                    // valid date, often near the calendar edges or in a year divisible by 4
                    case (k)
                        0: y = MIN_YEAR;
                        1: y = MAX_YEAR;
                        2: y = 14'(4 * $urandom_range(1, MAX_YEAR / 4));
                        default: y = 14'($urandom_range(1, MAX_YEAR));
                    endcase
                    m   = 4'($urandom_range(MON_JAN, MON_DEC));
                    len = trk.days_in(m, y);
                    d   = 5'($urandom_range(DAY_FIRST, len));
                    if (k == 0 && $urandom_range(1) == 1) begin
                        m = MON_JAN;
                        d = 5'($urandom_range(1, 3));
                    end else if (k == 1 && $urandom_range(1) == 1) begin
                        m = MON_DEC;
                        d = 5'($urandom_range(29, 31));
                    end
                end else begin
                    // at least one field out of range
                    if (k < 3) begin
                        m = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
                    end else if (k < 6) begin
                        y = ($urandom_range(1) == 0) ? 14'd0 :
                            14'($urandom_range(MAX_YEAR + 1, 16383));
                    end else begin
                        m   = 4'($urandom_range(MON_JAN, MON_DEC));
                        y   = 14'($urandom_range(1, MAX_YEAR));
                        len = trk.days_in(m, y);
                        d   = (len == LEN_31 || $urandom_range(1) == 0) ? 5'd0 :
                              5'($urandom_range(len + 1, 31));
                    end
                end
            end else if (pick < 55) begin
                act = ACT_NEXT;
            end else if (pick < 80) begin
                act = ACT_PREV;
            end else begin
                act = ACT_BACK_N;
                // long counts are rare to keep the run short
                if ($urandom_range(49) != 0)
                    c = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 400));
            end
            send_item(act, d, m, y, c);
        end

        // wait for the last replies, then a few quiet cycles
        drain();
        repeat (20) @(posedge aclk);
        $display("covered %0d transactions: next %0d, previous %0d, load %0d, step back %0d",
                 trk.requests, trk.per_action[ACT_NEXT], trk.per_action[ACT_PREV],
                 trk.per_action[ACT_LOAD], trk.per_action[ACT_BACK_N]);
        $display("replies ok %0d, rejected loads %0d, held at a calendar limit %0d",
                 trk.per_status[STAT_OK], trk.per_status[STAT_INVALID],
                 trk.per_status[STAT_LIMIT]);
        if (trk.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // result side: random ready, one long hold-off, one stretch always ready
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (trk.replies == 120 && !held_off) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            m_ready <= (trk.replies >= 250 && trk.replies < 330) ||
                       ($urandom_range(99) >= 19);
            @(posedge aclk);
            if (m_valid && m_ready) begin
                trk.check_reply('{day: m_cur_day, month: m_cur_month,
                                  year: m_cur_year, status: m_status});
            end
        end
    end

    // watchdog
    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
